FILE: src/dithered_mono_frame_writer_macros.svh
// assertion macros for the frame writer checker
`ifndef DITHERED_MONO_FRAME_WRITER_MACROS_SVH
`define DITHERED_MONO_FRAME_WRITER_MACROS_SVH

// property that must hold in the same cycle
`define DMFW_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the following cycle
`define DMFW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/dmfw_pkg.sv
// ----------------------------------------------------------------------------
// dmfw_pkg
// shared constants, types and tables of the dithered mono frame writer
// ----------------------------------------------------------------------------
package dmfw_pkg;

    localparam int FB_COLS      = 200;
    localparam int FB_ROWS      = 200;
    localparam int ROW_BYTES    = (FB_COLS + 7) / 8;
    localparam int STORE_BYTES  = ROW_BYTES * FB_ROWS;
    localparam int ADDR_W       = $clog2(STORE_BYTES);

    typedef enum logic [2:0] {
        CMD_SET_WIN  = 3'd0,
        CMD_PUSH     = 3'd1,
        CMD_FILL     = 3'd2,
        CMD_DRAW     = 3'd3,
        CMD_READ     = 3'd4,
        CMD_TAKE     = 3'd5
    } cmd_t;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic wr;
        logic step;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic job_go;
        logic last;
    } ctl_stat_t;

    function automatic logic [7:0] bayer_thr(input logic [3:0] idx);
        logic [7:0] t;
        case (idx)
            4'd0:    t = 8'd8;
            4'd1:    t = 8'd200;
            4'd2:    t = 8'd40;
            4'd3:    t = 8'd232;
            4'd4:    t = 8'd72;
            4'd5:    t = 8'd136;
            4'd6:    t = 8'd104;
            4'd7:    t = 8'd168;
            4'd8:    t = 8'd56;
            4'd9:    t = 8'd248;
            4'd10:   t = 8'd24;
            4'd11:   t = 8'd216;
            4'd12:   t = 8'd120;
            4'd13:   t = 8'd184;
            4'd14:   t = 8'd88;
            default: t = 8'd152;
        endcase
        return t;
    endfunction

endpackage

FILE: src/dmfw_datapath.sv
// ----------------------------------------------------------------------------
// dmfw_datapath
// frame store, window, cursor, dirty box and byte read-modify-write logic
// ----------------------------------------------------------------------------
module dmfw_datapath
    import dmfw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctl_cmd_t    ctl,
    output ctl_stat_t   stat,
    input  logic [2:0]  command,
    input  logic [7:0]  x_start,
    input  logic [7:0]  y_start,
    input  logic [7:0]  x_end,
    input  logic [7:0]  y_end,
    input  logic [15:0] color565,
    output logic        pixel_bit,
    output logic        dirty_any,
    output logic [7:0]  dirty_left,
    output logic [7:0]  dirty_top,
    output logic [7:0]  dirty_right,
    output logic [7:0]  dirty_bottom
);

    localparam logic [8:0] PW9  = 9'(FB_COLS);
    localparam logic [8:0] PH9  = 9'(FB_ROWS);
    localparam logic [7:0] XMAX = 8'(FB_COLS - 1);
    localparam logic [7:0] YMAX = 8'(FB_ROWS - 1);

    logic [7:0] mem [STORE_BYTES];

    cmd_t       cmd_reg;
    logic [7:0] xs_reg, ys_reg, xe_reg, ye_reg, luma_reg;
    logic [7:0] lo_reg, hi_reg, yend_reg, cur_y_reg;
    logic [4:0] cur_bx_reg;
    logic       go_reg, fill_ok_reg, pix_reg;
    logic [7:0] rd_data_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [7:0] win_l_reg, win_t_reg, win_r_reg, win_b_reg;
    logic [7:0] col_reg, row_reg;
    logic       dflag_reg;
    logic [7:0] dl_reg, dt_reg, dr_reg, db_reg;

    logic       pix_out_reg, dany_out_reg;
    logic [7:0] dl_out_reg, dt_out_reg, dr_out_reg, db_out_reg;

    // luma of the incoming colour
    logic [9:0] luma_sum;
    assign luma_sum = {2'b00, color565[15:11], 3'b000}
                    + {1'b0, color565[10:5], 3'b000}
                    + {2'b00, color565[4:0], 3'b000};

    // job set-up at load
    logic [7:0] lo_next, hi_next, y_next, yend_next;
    logic       go_next, fill_ok;
    logic [7:0] xe_clip, ye_clip;

    assign xe_clip = ({1'b0, x_end} > {1'b0, XMAX}) ? XMAX : x_end;
    assign ye_clip = ({1'b0, y_end} > {1'b0, YMAX}) ? YMAX : y_end;
    assign fill_ok = (x_start <= x_end) && (y_start <= y_end);

    always_comb
    begin
        lo_next   = x_start;
        hi_next   = x_start;
        y_next    = y_start;
        yend_next = y_start;
        go_next   = 1'b0;
        case (command)
            CMD_PUSH:
            begin
                lo_next   = col_reg;
                hi_next   = col_reg;
                y_next    = row_reg;
                yend_next = row_reg;
                go_next   = ({1'b0, col_reg} < PW9) && ({1'b0, row_reg} < PH9);
            end
            CMD_DRAW, CMD_READ:
            begin
                go_next = ({1'b0, x_start} < PW9) && ({1'b0, y_start} < PH9);
            end
            CMD_FILL:
            begin
                hi_next   = xe_clip;
                yend_next = ye_clip;
                go_next   = fill_ok && ({1'b0, x_start} < PW9)
                          && ({1'b0, y_start} < PH9);
            end
            default:
            begin
                go_next = 1'b0;
            end
        endcase
    end

    assign stat.job_go   = go_next;
    assign stat.last     = (cur_bx_reg == hi_reg[7:3]) && (cur_y_reg == yend_reg);
    assign stat.clr_done = (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1));

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= cmd_t'(command);
            xs_reg      <= x_start;
            ys_reg      <= y_start;
            xe_reg      <= x_end;
            ye_reg      <= y_end;
            luma_reg    <= luma_sum[9:2];
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            yend_reg    <= yend_next;
            go_reg      <= go_next;
            fill_ok_reg <= fill_ok;
            cur_bx_reg  <= lo_next[7:3];
            cur_y_reg   <= y_next;
        end
        else if (ctl.step)
        begin
            if (cur_bx_reg == hi_reg[7:3])
            begin
                cur_bx_reg <= lo_reg[7:3];
                cur_y_reg  <= cur_y_reg + 8'd1;
            end
            else
            begin
                cur_bx_reg <= cur_bx_reg + 5'd1;
            end
        end
    end

    // byte address and new byte value
    logic [ADDR_W-1:0] job_addr;
    logic [7:0]        byte_next;
    logic              is_read;

    assign is_read  = (cmd_reg == CMD_READ);
    assign job_addr = ADDR_W'(cur_y_reg * ROW_BYTES) + ADDR_W'(cur_bx_reg);

    always_comb
    begin
        logic [7:0] x;
        logic [8:0] s;
        for (int i = 0; i < 8; i++)
        begin
            x = {cur_bx_reg, 3'(i)};
            s = {1'b0, luma_reg} + {1'b0, bayer_thr({cur_y_reg[1:0], x[1:0]})};
            if (x >= lo_reg && x <= hi_reg)
                byte_next[7 - i] = s[8];
            else
                byte_next[7 - i] = rd_data_reg[7 - i];
        end
    end

    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [7:0]        mem_wd;

    assign mem_we = ctl.clr || (ctl.wr && !is_read);
    assign mem_wa = ctl.clr ? clr_cnt_reg : job_addr;
    assign mem_wd = ctl.clr ? 8'h00 : byte_next;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (ctl.rd)
            rd_data_reg <= mem[job_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (ctl.clr)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            pix_reg <= 1'b0;
        else if (ctl.wr && is_read)
            pix_reg <= rd_data_reg[~lo_reg[2:0]];
    end

    // rectangle merged into the dirty box at the end of the command
    logic       m_en;
    logic [7:0] mxs, mys, mxe, mye, mxe_c, mye_c;
    logic       m_ok;
    logic [7:0] m_l, m_r;
    logic       dflag_next;
    logic [7:0] dl_next, dt_next, dr_next, db_next;

    always_comb
    begin
        m_en = 1'b0;
        mxs  = xs_reg;
        mys  = ys_reg;
        mxe  = xe_reg;
        mye  = ye_reg;
        case (cmd_reg)
            CMD_PUSH:
            begin
                m_en = 1'b1;
                mxs  = win_l_reg;
                mys  = win_t_reg;
                mxe  = win_r_reg;
                mye  = win_b_reg;
            end
            CMD_FILL:
            begin
                m_en = fill_ok_reg;
            end
            CMD_DRAW:
            begin
                m_en = go_reg;
                mxe  = xs_reg;
                mye  = ys_reg;
            end
            default:
            begin
                m_en = 1'b0;
            end
        endcase
    end

    assign mxe_c = ({1'b0, mxe} > {1'b0, XMAX}) ? XMAX : mxe;
    assign mye_c = ({1'b0, mye} > {1'b0, YMAX}) ? YMAX : mye;
    assign m_ok  = m_en && (mxs <= mxe_c) && (mys <= mye_c);
    assign m_l   = {mxs[7:3], 3'b000};
    assign m_r   = {mxe_c[7:3], 3'b111};

    always_comb
    begin
        dflag_next = dflag_reg;
        dl_next    = dl_reg;
        dt_next    = dt_reg;
        dr_next    = dr_reg;
        db_next    = db_reg;
        if (m_ok)
        begin
            dflag_next = 1'b1;
            if (!dflag_reg)
            begin
                dl_next = m_l;
                dt_next = mys;
                dr_next = m_r;
                db_next = mye_c;
            end
            else
            begin
                dl_next = (m_l < dl_reg) ? m_l : dl_reg;
                dt_next = (mys < dt_reg) ? mys : dt_reg;
                dr_next = (m_r > dr_reg) ? m_r : dr_reg;
                db_next = (mye_c > db_reg) ? mye_c : db_reg;
            end
        end
    end

    // cursor stepping inside the window
    logic [7:0] col_next, row_next;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if ({1'b0, col_reg} + 9'd1 > {1'b0, win_r_reg})
        begin
            col_next = win_l_reg;
            if ({1'b0, row_reg} + 9'd1 > {1'b0, win_b_reg})
                row_next = win_t_reg;
            else
                row_next = row_reg + 8'd1;
        end
        else
        begin
            col_next = col_reg + 8'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_l_reg <= '0;
            win_t_reg <= '0;
            win_r_reg <= '0;
            win_b_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            dflag_reg <= 1'b0;
            dl_reg    <= '0;
            dt_reg    <= '0;
            dr_reg    <= '0;
            db_reg    <= '0;
        end
        else if (ctl.finish)
        begin
            case (cmd_reg)
                CMD_SET_WIN:
                begin
                    win_l_reg <= xs_reg;
                    win_t_reg <= ys_reg;
                    win_r_reg <= xe_reg;
                    win_b_reg <= ye_reg;
                    col_reg   <= xs_reg;
                    row_reg   <= ys_reg;
                end
                CMD_PUSH:
                begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end
                CMD_FILL:
                begin
                    if (fill_ok_reg)
                    begin
                        win_l_reg <= xs_reg;
                        win_t_reg <= ys_reg;
                        win_r_reg <= xe_reg;
                        win_b_reg <= ye_reg;
                    end
                end
                default:
                begin
                end
            endcase
            if (cmd_reg == CMD_TAKE)
            begin
                dflag_reg <= 1'b0;
                dl_reg    <= '0;
                dt_reg    <= '0;
                dr_reg    <= '0;
                db_reg    <= '0;
            end
            else
            begin
                dflag_reg <= dflag_next;
                dl_reg    <= dl_next;
                dt_reg    <= dt_next;
                dr_reg    <= dr_next;
                db_reg    <= db_next;
            end
        end
    end

    // result register, take dirty reports the box before the clear
    always_ff @(posedge clk)
    begin
        if (ctl.finish)
        begin
            pix_out_reg  <= pix_reg;
            dany_out_reg <= dflag_next;
            dl_out_reg   <= dl_next;
            dt_out_reg   <= dt_next;
            dr_out_reg   <= dr_next;
            db_out_reg   <= db_next;
        end
    end

    assign pixel_bit    = pix_out_reg;
    assign dirty_any    = dany_out_reg;
    assign dirty_left   = dl_out_reg;
    assign dirty_top    = dt_out_reg;
    assign dirty_right  = dr_out_reg;
    assign dirty_bottom = db_out_reg;

endmodule

FILE: src/dmfw_controller.sv
// ----------------------------------------------------------------------------
// dmfw_controller
// command sequencer: store clearing, byte read-modify-write walk, result hand-off
// ----------------------------------------------------------------------------
module dmfw_controller
    import dmfw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  ctl_stat_t stat,
    output ctl_cmd_t  ctl
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        ctl.clr    = (state_reg == S_CLEAR);
        ctl.load   = (state_reg == S_IDLE) && in_valid;
        ctl.rd     = (state_reg == S_READ);
        ctl.wr     = (state_reg == S_WRITE);
        ctl.step   = (state_reg == S_WRITE) && !stat.last;
        // result register must be free before the next item lands in it
        ctl.finish = (state_reg == S_FIN) && !(out_valid_reg && out_stall);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (stat.clr_done)
                    state_next = S_IDLE;
            S_IDLE:
                if (in_valid)
                    state_next = stat.job_go ? S_READ : S_FIN;
            S_READ:
                state_next = S_WRITE;
            S_WRITE:
                state_next = stat.last ? S_FIN : S_READ;
            S_FIN:
                if (ctl.finish)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase

        if (ctl.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: src/dithered_mono_frame_writer.sv
// sequencing: commands that touch no pixel go straight to the result register;
// push and draw on the panel read and rewrite one byte, read on the panel reads one
// byte, fill reads and rewrites each byte in turn; the next item is taken only once
// the result has been registered, and later while the output is stalled
// reset: asynchronous, active low; afterwards a clearing pass writes zero to
// all 5000 frame-store bytes, one per cycle, with input stalled until it ends
// ----------------------------------------------------------------------------
// dithered_mono_frame_writer
// 1-bit dithered frame store with window cursor, fill and dirty rectangle
// ----------------------------------------------------------------------------
module dithered_mono_frame_writer
    import dmfw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [7:0]  x_start,
    input  logic [7:0]  y_start,
    input  logic [7:0]  x_end,
    input  logic [7:0]  y_end,
    input  logic [15:0] color565,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pixel_bit,
    output logic        dirty_any,
    output logic [7:0]  dirty_left,
    output logic [7:0]  dirty_top,
    output logic [7:0]  dirty_right,
    output logic [7:0]  dirty_bottom
);

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    dmfw_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctl       (ctl)
    );

    dmfw_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .stat         (stat),
        .command      (command),
        .x_start      (x_start),
        .y_start      (y_start),
        .x_end        (x_end),
        .y_end        (y_end),
        .color565     (color565),
        .pixel_bit    (pixel_bit),
        .dirty_any    (dirty_any),
        .dirty_left   (dirty_left),
        .dirty_top    (dirty_top),
        .dirty_right  (dirty_right),
        .dirty_bottom (dirty_bottom)
    );

endmodule

FILE: src/dmfw_checker.sv
// ----------------------------------------------------------------------------
// dmfw_checker
// port-level checks of the frame writer results
// ----------------------------------------------------------------------------
`include "dithered_mono_frame_writer_macros.svh"

module dmfw_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic       pixel_bit,
    input logic       dirty_any,
    input logic [7:0] dirty_left,
    input logic [7:0] dirty_top,
    input logic [7:0] dirty_right,
    input logic [7:0] dirty_bottom
);

    logic [33:0] result_bits;
    logic        box_zero;
    logic        box_ok;

    assign result_bits = {pixel_bit, dirty_any, dirty_left, dirty_top,
                          dirty_right, dirty_bottom};
    assign box_zero    = (dirty_left | dirty_top | dirty_right | dirty_bottom) == 8'd0;
    assign box_ok      = (dirty_left[2:0] == 3'd0) && (dirty_right[2:0] == 3'd7)
                       && (dirty_left <= dirty_right) && (dirty_top <= dirty_bottom);

    `DMFW_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid, "result dropped while stalled")

    `DMFW_ASSERT_NEXT(a_hold_data, out_valid && out_stall, $stable(result_bits), "result changed")

    // an empty box reports zero bounds
    `DMFW_ASSERT(a_empty_zero, out_valid && !dirty_any, box_zero, "empty dirty box not zero")

    // a live box is byte aligned and ordered
    `DMFW_ASSERT(a_box_shape, out_valid && dirty_any, box_ok, "dirty box malformed")

endmodule

bind dithered_mono_frame_writer dmfw_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_bit    (pixel_bit),
    .dirty_any    (dirty_any),
    .dirty_left   (dirty_left),
    .dirty_top    (dirty_top),
    .dirty_right  (dirty_right),
    .dirty_bottom (dirty_bottom)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the dithered mono frame writer: every command is mirrored in a local
// frame store and dirty box, and each status item is compared on arrival;
// directed corner commands first, then window/push runs and random commands
// under four idling patterns
// ----------------------------------------------------------------------------
module testbench;
    import dmfw_pkg::*;

    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;
    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        logic [2:0]  cmd;
        logic [7:0]  xs;
        logic [7:0]  ys;
        logic [7:0]  xe;
        logic [7:0]  ye;
        logic [15:0] color;
    } frame_cmd_t;

    typedef struct {
        logic       pix;
        logic       any;
        logic [7:0] left;
        logic [7:0] top;
        logic [7:0] right;
        logic [7:0] bottom;
    } frame_status_t;

    class frame_scoreboard;
        logic [7:0]    pixels [STORE_BYTES];
        int            wl, wt, wr, wb, cc, cr;
        bit            dflag;
        int            box [4];
        frame_status_t pending [$];
        int            errors;
        int            thr [16] = '{8, 200, 40, 232, 72, 136, 104, 168,
                                    56, 248, 24, 216, 120, 184, 88, 152};

        function new();
            foreach (pixels[i]) pixels[i] = 8'h00;
            wl = 0; wt = 0; wr = 0; wb = 0; cc = 0; cr = 0;
            dflag = 0;
            foreach (box[i]) box[i] = 0;
            errors = 0;
        endfunction

        function void put_bit(int x, int y, int luma);
            int idx;
            logic [7:0] mask;
            if (x >= FB_COLS || y >= FB_ROWS) return;
            idx = y * ROW_BYTES + (x >> 3);
            mask = 8'h80 >> (x & 7);
            if (luma + thr[(x & 3) | ((y & 3) << 2)] >= 256)
                pixels[idx] = pixels[idx] | mask;
            else
                pixels[idx] = pixels[idx] & ~mask;
        endfunction

        function void grow_dirty(int xs, int ys, int xe, int ye);
            int l, r;
            if (xe > FB_COLS - 1) xe = FB_COLS - 1;
            if (ye > FB_ROWS - 1) ye = FB_ROWS - 1;
            if (xs > xe || ys > ye) return;
            l = xs & ~7;
            r = ((xe & ~7) + 7) & 8'hFF;
            if (!dflag)
            begin
                box = '{l, ys, r, ye};
                dflag = 1;
                return;
            end
            if (l < box[0]) box[0] = l;
            if (ys < box[1]) box[1] = ys;
            if (r > box[2]) box[2] = r;
            if (ye > box[3]) box[3] = ye;
        endfunction

        function void note_input(frame_cmd_t it);
            int luma, xs, ys, xe, ye;
            frame_status_t st;
            xs = int'(it.xs); ys = int'(it.ys); xe = int'(it.xe); ye = int'(it.ye);
            luma = ((int'(it.color[15:11]) << 3) + (int'(it.color[10:5]) << 3)
                    + (int'(it.color[4:0]) << 3)) >> 2;
            st.pix = 1'b0;
            case (it.cmd)
                CMD_SET_WIN:
                begin
                    wl = xs; wt = ys; wr = xe; wb = ye; cc = xs; cr = ys;
                end
                CMD_PUSH:
                begin
                    grow_dirty(wl, wt, wr, wb);
                    put_bit(cc, cr, luma);
                    if (cc + 1 > wr)
                    begin
                        cc = wl;
                        cr = (cr + 1 > wb) ? wt : cr + 1;
                    end
                    else
                        cc = cc + 1;
                end
                CMD_FILL:
                begin
                    if (xs <= xe && ys <= ye)
                    begin
                        wl = xs; wt = ys; wr = xe; wb = ye;
                        grow_dirty(xs, ys, xe, ye);
                        for (int y = ys; y <= ye && y < FB_ROWS; y++)
                            for (int x = xs; x <= xe && x < FB_COLS; x++)
                                put_bit(x, y, luma);
                    end
                end
                CMD_DRAW:
                begin
                    if (xs < FB_COLS && ys < FB_ROWS)
                    begin
                        grow_dirty(xs, ys, xs, ys);
                        put_bit(xs, ys, luma);
                    end
                end
                CMD_READ:
                begin
                    if (xs < FB_COLS && ys < FB_ROWS)
                        st.pix = pixels[ys * ROW_BYTES + (xs >> 3)][7 - (xs & 7)];
                end
                default: ;
            endcase
            st.any = dflag;
            st.left = 8'(box[0]); st.top = 8'(box[1]);
            st.right = 8'(box[2]); st.bottom = 8'(box[3]);
            if (it.cmd == CMD_TAKE)
            begin
                dflag = 0;
                foreach (box[i]) box[i] = 0;
            end
            pending.push_back(st);
        endfunction

        function void compare(string name, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(frame_status_t got);
            frame_status_t want;
            if (pending.size() == 0)
            begin
                $error("status item with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            compare("pixel_bit", int'(want.pix), int'(got.pix));
            compare("dirty_any", int'(want.any), int'(got.any));
            compare("dirty_left", int'(want.left), int'(got.left));
            compare("dirty_top", int'(want.top), int'(got.top));
            compare("dirty_right", int'(want.right), int'(got.right));
            compare("dirty_bottom", int'(want.bottom), int'(got.bottom));
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [2:0]  command = 0;
    logic [7:0]  x_start = 0;
    logic [7:0]  y_start = 0;
    logic [7:0]  x_end = 0;
    logic [7:0]  y_end = 0;
    logic [15:0] color565 = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic        pixel_bit;
    logic        dirty_any;
    logic [7:0]  dirty_left, dirty_top, dirty_right, dirty_bottom;

    frame_scoreboard sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int quiet_cycles = 0;

    dithered_mono_frame_writer dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    // stalls and valids change only at rising edges, so the falling edge sees
    // what the next rising edge will act on
    always @(negedge clk)
    begin
        if (out_valid && !out_stall)
            sb.check_result('{pixel_bit, dirty_any, dirty_left, dirty_top,
                              dirty_right, dirty_bottom});
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send(frame_cmd_t it);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= it.cmd;
        x_start  <= it.xs;
        y_start  <= it.ys;
        x_end    <= it.xe;
        y_end    <= it.ye;
        color565 <= it.color;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        sb.note_input(it);
    endtask

    // the last item has just been taken, so valid drops before the block is free
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] pick_coord();
        int k;
        k = $urandom_range(99);
        if (k < 70) return 8'($urandom_range(199));
        if (k < 85) return 8'($urandom_range(255, 200));
        return (k < 92) ? 8'd0 : 8'd199;
    endfunction

    // most fills stay small, the odd one covers whatever the fields give
    task automatic send_fill();
        frame_cmd_t it;
        it.cmd = CMD_FILL;
        it.color = 16'($urandom);
        it.xs = pick_coord();
        it.ys = pick_coord();
        if ($urandom_range(99) < 4)
        begin
            it.xe = 8'($urandom); it.ye = 8'($urandom);
        end
        else if ($urandom_range(99) < 10)
        begin
            it.xe = it.xs - 8'($urandom_range(1, 5)); it.ye = it.ys;
        end
        else
        begin
            it.xe = (int'(it.xs) + 15 > 255) ? 8'd255 : it.xs + 8'($urandom_range(15));
            it.ye = (int'(it.ys) + 7 > 255) ? 8'd255 : it.ys + 8'($urandom_range(7));
        end
        send(it);
    endtask

    task automatic random_part(int count);
        frame_cmd_t it;
        int n, k;
        n = 0;
        while (n < count)
        begin
            k = $urandom_range(99);
            if (k < 40)
            begin
                // window followed by a run of pushes that can wrap
                it.cmd = CMD_SET_WIN;
                it.xs = pick_coord(); it.ys = pick_coord();
                it.xe = ($urandom_range(9) == 0) ? it.xs - 8'd3
                        : ((int'(it.xs) + 6 > 255) ? 8'd255 : it.xs + 8'($urandom_range(6)));
                it.ye = ($urandom_range(9) == 0) ? it.ys - 8'd1
                        : ((int'(it.ys) + 3 > 255) ? 8'd255 : it.ys + 8'($urandom_range(3)));
                it.color = 16'($urandom);
                send(it);
                n++;
                repeat ($urandom_range(20, 1))
                begin
                    it.cmd = CMD_PUSH;
                    it.xs = 8'($urandom); it.ys = 8'($urandom);
                    it.xe = 8'($urandom); it.ye = 8'($urandom);
                    it.color = 16'($urandom);
                    send(it);
                    n++;
                end
            end
            else if (k < 52)
            begin
                send_fill();
                n++;
            end
            else
            begin
                it.xs = pick_coord(); it.ys = pick_coord();
                it.xe = 8'($urandom); it.ye = 8'($urandom); it.color = 16'($urandom);
                if (k < 70) it.cmd = CMD_DRAW;
                else if (k < 88) it.cmd = CMD_READ;
                else if (k < 95) it.cmd = CMD_TAKE;
                else it.cmd = (k < 97) ? CMD_SPARE_6 : CMD_SPARE_7;
                send(it);
                n++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send('{CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000});
        send('{CMD_TAKE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000});
        send('{CMD_DRAW, 8'd0, 8'd0, 8'hFF, 8'hFF, 16'hFFFF});
        send('{CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000});
        send('{CMD_DRAW, 8'd199, 8'd199, 8'd0, 8'd0, 16'hFFFF});
        send('{CMD_DRAW, 8'd200, 8'd5, 8'd0, 8'd0, 16'hFFFF});
        send('{CMD_DRAW, 8'd255, 8'd255, 8'd0, 8'd0, 16'hFFFF});
        send('{CMD_READ, 8'd255, 8'd255, 8'd0, 8'd0, 16'h0000});
        send('{CMD_READ, 8'd199, 8'd199, 8'd0, 8'd0, 16'h0000});
        send('{CMD_TAKE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000});
        send('{CMD_FILL, 8'd0, 8'd0, 8'd255, 8'd255, 16'hFFFF});
        send('{CMD_FILL, 8'd9, 8'd3, 8'd4, 8'd7, 16'h0000});
        send('{CMD_FILL, 8'd3, 8'd9, 8'd7, 8'd2, 16'h0000});
        send('{CMD_FILL, 8'd190, 8'd195, 8'd230, 8'd250, 16'h8410});
        send('{CMD_READ, 8'd198, 8'd196, 8'd0, 8'd0, 16'h0000});
        send('{CMD_SET_WIN, 8'd254, 8'd198, 8'd255, 8'd201, 16'h0000});
        repeat (9) send('{CMD_PUSH, 8'd0, 8'd0, 8'd0, 8'd0, 16'hF800});
        send('{CMD_SET_WIN, 8'd20, 8'd20, 8'd10, 8'd10, 16'h0000});
        send('{CMD_PUSH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h07E0});
        send('{CMD_PUSH, 8'd0, 8'd0, 8'd0, 8'd0, 16'h001F});
        send('{CMD_SPARE_6, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF});
        send('{CMD_SPARE_7, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000});
        send('{CMD_TAKE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000});
        drain();

        random_part(400);
        drain();
        send_idle = 46;
        random_part(400);
        drain();
        send_idle = 0;
        recv_idle = 46;
        random_part(400);
        drain();
        send_idle = 38;
        recv_idle = 38;
        random_part(400);

        drain();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
